/* design/linear_array_queue_assert.svh */
// Assertion macros used by the linear array queue datapath.
// Every macro samples on the rising clock edge and is disabled while reset is low.
`ifndef LINEAR_ARRAY_QUEUE_ASSERT_SVH
`define LINEAR_ARRAY_QUEUE_ASSERT_SVH

// Plain property check.
`define LAQ_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Same-cycle implication.
`define LAQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LAQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/laq_pkg.sv */
// ----------------------------------------------------------------------------
// laq_pkg
// Types, widths and codes that are shared by the linear array queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package laq_pkg;

  localparam int unsigned DEPTH  = 8;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_DISPLAY = 2'd3
  } laq_cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } laq_status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;       // Latch the incoming command and start the cursor at the head.
    logic ram_wr;        // Store the incoming value at the tail.
    logic ram_rd_head;   // Read the entry at the head.
    logic ram_rd_next;   // Advance the cursor and read the following entry.
    logic out_load;      // Load the output register.
    logic out_from_ram;  // Output register takes the RAM read data.
    logic deq_update;    // Remove the head entry.
  } laq_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic     full;
    logic     empty;
    logic     cur_last;
    logic     out_free;
    laq_cmd_e in_cmd;
    laq_cmd_e cmd;
  } laq_stat_t;

endpackage

`default_nettype wire

/* design/laq_if.sv */
// ----------------------------------------------------------------------------
// laq_in_if / laq_out_if
// Valid/ready channels that carry queue commands and queue results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface laq_in_if;
  import laq_pkg::*;

  logic                     valid;
  logic                     ready;
  laq_cmd_e                 cmd;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface laq_out_if;
  import laq_pkg::*;

  logic                     valid;
  logic                     ready;
  laq_status_e              status;
  logic signed [DATA_W-1:0] data;
  logic                     last;

  modport source (output valid, output status, output data, output last, input ready);
  modport sink   (input valid, input status, input data, input last, output ready);
endinterface

`default_nettype wire

/* design/laq_ram.sv */
// ----------------------------------------------------------------------------
// laq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module laq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic                                       re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* design/laq_ctrl.sv */
// ----------------------------------------------------------------------------
// laq_ctrl
// Controller state machine: decodes commands and sequences RAM reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module laq_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire laq_pkg::laq_stat_t  stat_i,
  output laq_pkg::laq_ctrl_t       ctrl_o
);
  import laq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } laq_state_e;

  laq_state_e state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE) && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ctrl_o.capture = 1'b1;
          unique case (stat_i.in_cmd)
            CMD_ENQUEUE: begin
              ctrl_o.out_load = 1'b1;
              ctrl_o.ram_wr   = !stat_i.full;
            end
            CMD_DEQUEUE, CMD_PEEK, CMD_DISPLAY: begin
              if (stat_i.empty) begin
                ctrl_o.out_load = 1'b1;
              end else begin
                ctrl_o.ram_rd_head = 1'b1;
                state_d            = S_READ;
              end
            end
          endcase
        end
      end
      S_READ: begin
        // The read data stays put in the RAM output register while the sink stalls.
        if (stat_i.out_free) begin
          ctrl_o.out_load     = 1'b1;
          ctrl_o.out_from_ram = 1'b1;
          ctrl_o.deq_update   = (stat_i.cmd == CMD_DEQUEUE);
          if ((stat_i.cmd == CMD_DISPLAY) && !stat_i.cur_last) begin
            ctrl_o.ram_rd_next = 1'b1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* design/laq_datapath.sv */
// ----------------------------------------------------------------------------
// laq_datapath
// Queue indices, entry RAM, read cursor and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "linear_array_queue_assert.svh"

module laq_datapath (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire laq_pkg::laq_ctrl_t                   ctrl_i,
  output laq_pkg::laq_stat_t                        stat_o,
  input  wire laq_pkg::laq_cmd_e                    in_cmd_i,
  input  wire logic signed [laq_pkg::DATA_W-1:0]    in_value_i,
  input  wire logic                                 out_ready_i,
  output logic                                      out_valid_o,
  output laq_pkg::laq_status_e                      out_status_o,
  output logic signed [laq_pkg::DATA_W-1:0]         out_data_o,
  output logic                                      out_last_o
);
  import laq_pkg::*;

  logic [CNT_W-1:0]  write_count_q, write_count_d;
  logic [IDX_W-1:0]  read_index_q, read_index_d;
  logic [IDX_W-1:0]  cursor_q, cursor_d;
  laq_cmd_e          cmd_q, cmd_d;
  logic              out_valid_q, out_valid_d;
  laq_status_e       out_status_q, out_status_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic              out_last_q, out_last_d;

  logic              full, empty, cur_last, out_free;
  logic [IDX_W-1:0]  cursor_inc;
  logic [IDX_W-1:0]  raddr;
  logic [DATA_W-1:0] rdata;

  assign full       = (write_count_q == CNT_FULL);
  assign empty      = (write_count_q == '0);
  assign cursor_inc = cursor_q + IDX_W'(1);
  // The cursor points at the final held entry when one more reaches the write count.
  assign cur_last   = ((CNT_W'(cursor_q) + CNT_W'(1)) == write_count_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign raddr      = ctrl_i.ram_rd_head ? read_index_q : cursor_inc;

  laq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.ram_wr),
    .waddr_i (write_count_q[IDX_W-1:0]),
    .wdata_i (in_value_i),
    .re_i    (ctrl_i.ram_rd_head || ctrl_i.ram_rd_next),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    write_count_d = write_count_q;
    read_index_d  = read_index_q;
    cursor_d      = cursor_q;
    cmd_d         = cmd_q;
    if (ctrl_i.capture) begin
      cmd_d    = in_cmd_i;
      cursor_d = read_index_q;
    end
    if (ctrl_i.ram_rd_next) begin
      cursor_d = cursor_inc;
    end
    if (ctrl_i.ram_wr) begin
      write_count_d = write_count_q + CNT_W'(1);
    end
    if (ctrl_i.deq_update) begin
      if (cur_last) begin
        write_count_d = '0;
        read_index_d  = '0;
      end else begin
        read_index_d = read_index_q + IDX_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_last_d   = out_last_q;
    if (ctrl_i.out_load) begin
      out_valid_d = 1'b1;
      if (ctrl_i.out_from_ram) begin
        out_status_d = ST_OK;
        out_data_d   = rdata;
        out_last_d   = (cmd_q != CMD_DISPLAY) || cur_last;
      end else begin
        out_data_d = '0;
        out_last_d = 1'b1;
        if (in_cmd_i == CMD_ENQUEUE) begin
          out_status_d = full ? ST_FULL : ST_OK;
        end else begin
          out_status_d = ST_EMPTY;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_count_q <= '0;
      read_index_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      write_count_q <= write_count_d;
      read_index_q  <= read_index_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cursor_q     <= cursor_d;
    cmd_q        <= cmd_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_last_q   <= out_last_d;
  end

  assign stat_o.full     = full;
  assign stat_o.empty    = empty;
  assign stat_o.cur_last = cur_last;
  assign stat_o.out_free = out_free;
  assign stat_o.in_cmd   = in_cmd_i;
  assign stat_o.cmd      = cmd_q;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_data_o   = out_data_q;
  assign out_last_o   = out_last_q;

  `LAQ_ASSERT(a_index_in_range, clk_i, rst_ni,
      (write_count_q <= CNT_FULL) && (empty ? (read_index_q == '0) :
      (CNT_W'(read_index_q) < write_count_q)), "queue indices out of range")
  `LAQ_ASSERT_IMP(a_no_write_when_full, clk_i, rst_ni, ctrl_i.ram_wr, !full,
      "entry written while queue full")
  `LAQ_ASSERT_IMP(a_load_only_when_free, clk_i, rst_ni, ctrl_i.out_load, out_free,
      "output register overwritten before it was taken")
  `LAQ_ASSERT_NEXT(a_drain_to_empty, clk_i, rst_ni, ctrl_i.deq_update && cur_last,
      (write_count_q == '0) && (read_index_q == '0), "queue not empty after last dequeue")

endmodule

`default_nettype wire

/* design/linear_array_queue.sv */
// Results: an enqueue, or any command on an empty queue, shows its result in the cycle
// after the transaction; dequeue and peek results pass the RAM read register, then the output register.
// Throughput: one item at a time; display gives one result per cycle after the first if the sink is ready.
// The next transaction is taken at the edge where the item's final result leaves the output register.
// Reset: asynchronous, active low; clears the queue indices, entries stay unknown until written.
// ----------------------------------------------------------------------------
// linear_array_queue
// Non-wrapping array queue with enqueue, dequeue, peek and display commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module linear_array_queue (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  laq_in_if.sink     in_i,
  laq_out_if.source  out_o
);
  import laq_pkg::*;

  laq_ctrl_t ctrl;
  laq_stat_t stat;
  logic      in_ready;

  laq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  laq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .in_cmd_i     (in_i.cmd),
    .in_value_i   (in_i.value),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_status_o (out_o.status),
    .out_data_o   (out_o.data),
    .out_last_o   (out_o.last)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire

/* tb/linear_array_queue_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_array_queue_tb
// Drives enqueue, dequeue, peek and display commands into the non-wrapping
// queue, computes the expected results with a local model of the queue, and
// checks every result transaction field by field, with random gaps on both
// channels.
// ----------------------------------------------------------------------------

module linear_array_queue_tb;
  import laq_pkg::*;

  typedef struct {
    laq_cmd_e                 cmd;
    logic signed [DATA_W-1:0] value;
  } queue_cmd_t;

  typedef struct {
    laq_status_e              status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } queue_result_t;

  logic clk_i;
  logic rst_ni;

  laq_in_if  in_if ();
  laq_out_if out_if ();

  linear_array_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  queue_cmd_t    pending_cmds[$];
  queue_result_t expected_results[$];

  // Local image of the queue.
  logic signed [DATA_W-1:0] q_mem [DEPTH];
  logic [CNT_W-1:0]         q_count;
  logic [IDX_W-1:0]         q_head;

  int total_cmds;
  int accepted_cmds;
  int checked_results;
  int error_count;
  int full_seen;
  int empty_seen;
  int display_seen;

  // Both channels run without gaps while the middle of the stimulus goes through.
  wire calm = (accepted_cmds >= 200) && (accepted_cmds < 300);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400us;
    $display("linear_array_queue_tb failed");
    $finish;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 31);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic push_result(input laq_status_e status, input logic signed [DATA_W-1:0] data,
                             input logic last);
    queue_result_t r;
    r.status = status;
    r.data   = data;
    r.last   = last;
    expected_results.push_back(r);
  endtask

  task automatic predict_queue(input laq_cmd_e cmd, input logic signed [DATA_W-1:0] value);
    if (cmd == CMD_ENQUEUE) begin
      if (q_count == CNT_FULL) begin
        push_result(ST_FULL, '0, 1'b1);
        full_seen++;
      end else begin
        q_mem[q_count] = value;
        q_count++;
        push_result(ST_OK, '0, 1'b1);
      end
    end else if (q_count == 0 || int'(q_head) >= int'(q_count)) begin
      push_result(ST_EMPTY, '0, 1'b1);
      empty_seen++;
    end else begin
      case (cmd)
        CMD_DEQUEUE: begin
          push_result(ST_OK, q_mem[q_head], 1'b1);
          // Taking the last held entry sends both indices back to zero.
          if (int'(q_head) + 1 >= int'(q_count)) begin
            q_head  = '0;
            q_count = '0;
          end else begin
            q_head++;
          end
        end
        CMD_PEEK: begin
          push_result(ST_OK, q_mem[q_head], 1'b1);
        end
        default: begin
          for (int i = q_head; i < int'(q_count); i++)
            push_result(ST_OK, q_mem[i], (i + 1 == int'(q_count)));
          display_seen++;
        end
      endcase
    end
  endtask

  // Driver: holds a transaction until it is taken, then loads the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        predict_queue(in_if.cmd, in_if.value);
        accepted_cmds++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_cmds.size() != 0 && !take_break()) begin
          in_if.valid <= 1'b1;
          in_if.cmd   <= pending_cmds[0].cmd;
          in_if.value <= pending_cmds[0].value;
          void'(pending_cmds.pop_front());
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status=%0d data=%h last=%b",
                                    out_if.status, out_if.data, out_if.last));
        end else begin
          if (out_if.status !== expected_results[0].status)
            report_mismatch($sformatf("status %0d, expected %0d", out_if.status,
                                      expected_results[0].status));
          if (out_if.data !== expected_results[0].data)
            report_mismatch($sformatf("data %h, expected %h", out_if.data,
                                      expected_results[0].data));
          if (out_if.last !== expected_results[0].last)
            report_mismatch($sformatf("last %b, expected %b", out_if.last,
                                      expected_results[0].last));
          void'(expected_results.pop_front());
        end
        checked_results++;
      end
      out_if.ready <= !take_break();
    end
  end

  task automatic add_cmd(input laq_cmd_e cmd, input logic signed [DATA_W-1:0] value);
    queue_cmd_t c;
    c.cmd   = cmd;
    c.value = value;
    pending_cmds.push_back(c);
  endtask

  function automatic logic signed [DATA_W-1:0] random_word();
    case ($urandom_range(9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0000_0000;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic laq_cmd_e random_cmd();
    return laq_cmd_e'(2'($urandom_range(3)));
  endfunction

  initial begin
    int fill;
    int extra;

    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.cmd    = CMD_ENQUEUE;
    in_if.value  = '0;
    out_if.ready = 1'b0;
    q_count      = '0;
    q_head       = '0;
    for (int i = 0; i < DEPTH; i++) q_mem[i] = '0;

    // Directed part: empty answers, filling to the top, full after dequeues,
    // displays of different lengths and the drain back to empty.
    add_cmd(CMD_PEEK, '0);
    add_cmd(CMD_DEQUEUE, '0);
    add_cmd(CMD_DISPLAY, 32'sh5a5a_5a5a);
    add_cmd(CMD_ENQUEUE, 32'sh7fff_ffff);
    add_cmd(CMD_ENQUEUE, 32'sh8000_0000);
    add_cmd(CMD_ENQUEUE, 32'sh0000_0000);
    add_cmd(CMD_ENQUEUE, -32'sd1);
    add_cmd(CMD_ENQUEUE, 32'shaaaa_aaaa);
    add_cmd(CMD_ENQUEUE, 32'sh5555_5555);
    add_cmd(CMD_ENQUEUE, 32'sh0000_0001);
    add_cmd(CMD_ENQUEUE, 32'sh1234_5678);
    add_cmd(CMD_ENQUEUE, 32'sh0bad_cafe);
    add_cmd(CMD_DISPLAY, '0);
    add_cmd(CMD_PEEK, '0);
    add_cmd(CMD_DEQUEUE, '0);
    add_cmd(CMD_DEQUEUE, '0);
    // The slots freed above are not reused, so this one must still be refused.
    add_cmd(CMD_ENQUEUE, 32'sh0000_00ff);
    add_cmd(CMD_DISPLAY, '0);
    for (int i = 0; i < 6; i++) add_cmd(CMD_DEQUEUE, '0);
    add_cmd(CMD_DEQUEUE, '0);
    add_cmd(CMD_ENQUEUE, 32'shdead_beef);
    add_cmd(CMD_PEEK, '0);
    add_cmd(CMD_DISPLAY, '0);
    add_cmd(CMD_DEQUEUE, '0);

    // Random part: mostly fill, work and drain sequences, the rest loose commands.
    total_cmds = pending_cmds.size() + 450;
    while (pending_cmds.size() < total_cmds) begin
      if ($urandom_range(9) < 7) begin
        fill = $urandom_range(1, DEPTH + 1);
        for (int i = 0; i < fill; i++) add_cmd(CMD_ENQUEUE, random_word());
        extra = $urandom_range(0, 4);
        for (int i = 0; i < extra; i++) add_cmd(random_cmd(), random_word());
        fill = $urandom_range(fill / 2, fill + 2);
        for (int i = 0; i < fill; i++)
          add_cmd(($urandom_range(3) == 0) ? CMD_DISPLAY : CMD_DEQUEUE, random_word());
      end else begin
        extra = $urandom_range(1, 6);
        for (int i = 0; i < extra; i++) add_cmd(random_cmd(), random_word());
      end
    end
    total_cmds = pending_cmds.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cmds != total_cmds || expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Ran %0d commands and checked %0d results.", accepted_cmds, checked_results);
    $display("Saw %0d full refusals, %0d empty answers and %0d displays.",
             full_seen, empty_seen, display_seen);
    if (error_count == 0) begin
      $display("linear_array_queue_tb passed");
    end else begin
      $display("linear_array_queue_tb failed");
    end
    $finish;
  end

endmodule
